>>> sv/uart_console_line_editor_defines.svh
// Assertion macros shared by the console line editor RTL.
`ifndef UART_CONSOLE_LINE_EDITOR_DEFINES_SVH
`define UART_CONSOLE_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define UCLE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define UCLE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ucle_pkg.sv
// Types and constants of the console line editor.
package ucle_pkg;

	localparam int BUFFER_DEPTH_DEF = 64;

	// Event codes carried in the mode field.
	localparam logic [1:0] MODE_RX = 2'd0;
	localparam logic [1:0] MODE_TX = 2'd1;
	localparam logic [1:0] MODE_RD = 2'd2;
	localparam logic [1:0] MODE_WR = 2'd3;

	// Character codes.
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_BRACK = 8'h5B;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
	} ucle_item_t;

	typedef struct packed {
		logic       line_valid;
		logic [7:0] line_byte;
		logic       host_valid;
		logic [7:0] host_byte;
		logic       accepted;
		logic [7:0] message_count;
		logic       send_irq_enable;
	} ucle_result_t;

	// Commands from the sequencer to one ring buffer.
	typedef struct packed {
		logic push;
		logic pop;
		logic drop;
	} ucle_ring_ctl_t;

	// Status of one ring buffer.
	typedef struct packed {
		logic empty;
		logic full;
	} ucle_ring_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_ECHO = 5'b00100,
		ST_READ = 5'b01000,
		ST_FIN  = 5'b10000
	} ucle_state_t;

endpackage

>>> sv/ucle_chan_if.sv
// Valid/ready channel interface carrying one payload per transfer.
interface ucle_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> sv/ucle_ring.sv
// Byte ring buffer on a synchronous memory with a registered read port.
`include "uart_console_line_editor_defines.svh"

module ucle_ring #(
	parameter int DEPTH = ucle_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ucle_pkg::ucle_ring_ctl_t  ctl,
	input  logic [7:0]                wdata,
	output ucle_pkg::ucle_ring_sts_t  sts,
	output logic [7:0]                rdata
);
	import ucle_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;
	logic [IW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [FW:0]   wr_sum;
	logic [FW:0]   wr_wrap;
	logic [IW-1:0] wr_idx;

	// Write slot is head plus fill, folded once into the ring.
	always_comb begin
		wr_sum  = (FW + 1)'(head_q) + (FW + 1)'(fill_q);
		wr_wrap = (wr_sum >= (FW + 1)'(DEPTH)) ? wr_sum - (FW + 1)'(DEPTH) : wr_sum;
		wr_idx  = wr_wrap[IW-1:0];
	end

	assign sts.empty = (fill_q == '0);
	assign sts.full  = (fill_q == FW'(DEPTH));
	assign rdata     = rd_data_q;

	// Head and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.push) begin
				fill_q <= fill_q + FW'(1);
			end else if (ctl.pop || ctl.drop) begin
				fill_q <= fill_q - FW'(1);
			end
			if (ctl.pop) begin
				head_q <= (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
			end
		end
	end

	// Memory write port.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_idx] <= wdata;
		end
	end

	// Memory read port, registered.
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			rd_data_q <= mem[head_q];
		end
	end

	`UCLE_ASSERT_IMP(a_push_room, ctl.push, !sts.full, "push into a full ring")
	`UCLE_ASSERT_IMP(a_pop_data, ctl.pop || ctl.drop, !sts.empty, "take from an empty ring")
	`UCLE_ASSERT_IMP(a_one_op, ctl.push, !ctl.pop && !ctl.drop, "push together with a take")

endmodule

>>> sv/uart_console_line_editor.sv
// Console line editor: receive and echo rings with backspace, escape filter and line count.
// Each event (received byte, transmitter slot, host read, host write) is one transfer on
// item and yields one transfer on result. A transmitter slot or host read that returns
// a byte passes through the read state, because the ring memories have a registered
// read port; a received carriage return or backspace that is echoed passes through the
// echo state, since each echo byte uses the single write port of the echo memory. A new
// event is accepted while the previous result still waits to be taken.
`include "uart_console_line_editor_defines.svh"

module uart_console_line_editor #(
	parameter int BUFFER_DEPTH = ucle_pkg::BUFFER_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ucle_chan_if.sink   item,
	ucle_chan_if.source result
);
	import ucle_pkg::*;

	ucle_state_t    state_q, state_d;
	logic [1:0]     mode_q;
	logic [7:0]     data_q;
	logic [7:0]     last_q, last_d;
	logic [7:0]     before_q, before_d;
	logic [7:0]     lines_q, lines_d;
	logic           irq_q, irq_d;
	logic [7:0]     pend0_q, pend0_d;
	logic [7:0]     pend1_q, pend1_d;
	logic [1:0]     pend_cnt_q, pend_cnt_d;
	logic           res_line_q, res_line_d;
	logic           res_host_q, res_host_d;
	logic           res_acc_q, res_acc_d;
	logic           out_valid_q;
	ucle_result_t   out_q;
	ucle_result_t   out_d;
	logic           out_free;
	logic           accept;
	logic           is_bs;
	logic           kept;
	logic           line_end;

	ucle_ring_ctl_t rx_ctl, echo_ctl;
	ucle_ring_sts_t rx_sts, echo_sts;
	logic [7:0]     rx_rdata, echo_rdata;
	logic [7:0]     echo_wdata;

	ucle_ring #(.DEPTH(BUFFER_DEPTH)) u_rx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rx_ctl),
		.wdata  (data_q),
		.sts    (rx_sts),
		.rdata  (rx_rdata)
	);

	ucle_ring #(.DEPTH(BUFFER_DEPTH)) u_echo_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (echo_ctl),
		.wdata  (echo_wdata),
		.sts    (echo_sts),
		.rdata  (echo_rdata)
	);

	assign item.ready     = (state_q == ST_IDLE);
	assign accept         = item.valid && item.ready;
	assign out_free       = !out_valid_q || result.ready;
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// Character classes of the byte being handled.
	assign is_bs    = (data_q == CH_BS) || (data_q == CH_DEL);
	assign kept     = (last_q != CH_BRACK) && (before_q != CH_ESC) &&
	                  (data_q != CH_ESC) && (data_q != CH_BRACK);
	assign line_end = (data_q == CH_CR) || ((data_q == CH_LF) && (last_q != CH_CR));

	// Result of the finished event.
	always_comb begin
		out_d.line_valid      = res_line_q;
		out_d.line_byte       = res_line_q ? echo_rdata : 8'h00;
		out_d.host_valid      = res_host_q;
		out_d.host_byte       = res_host_q ? rx_rdata : 8'h00;
		out_d.accepted        = res_acc_q;
		out_d.message_count   = lines_q;
		out_d.send_irq_enable = irq_q;
	end

	// Event sequencer.
	always_comb begin
		state_d    = state_q;
		last_d     = last_q;
		before_d   = before_q;
		lines_d    = lines_q;
		irq_d      = irq_q;
		pend0_d    = pend0_q;
		pend1_d    = pend1_q;
		pend_cnt_d = pend_cnt_q;
		res_line_d = res_line_q;
		res_host_d = res_host_q;
		res_acc_d  = res_acc_q;
		rx_ctl     = '0;
		echo_ctl   = '0;
		echo_wdata = data_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_line_d = 1'b0;
					res_host_d = 1'b0;
					res_acc_d  = 1'b0;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_FIN;
				unique case (mode_q)
					MODE_RX: begin
						before_d = last_q;
						last_d   = data_q;
						if (is_bs) begin
							if (!rx_sts.empty) begin
								rx_ctl.drop   = 1'b1;
								echo_ctl.push = !echo_sts.full;
								echo_wdata    = CH_BS;
								pend0_d       = CH_SPACE;
								pend1_d       = CH_BS;
								pend_cnt_d    = 2'd2;
								irq_d         = 1'b1;
								state_d       = ST_ECHO;
							end
						end else if (kept) begin
							if (line_end && (lines_q != 8'hFF)) begin
								lines_d = lines_q + 8'd1;
							end
							rx_ctl.push = !rx_sts.full;
							if (!echo_sts.full) begin
								echo_ctl.push = 1'b1;
								irq_d         = 1'b1;
								if (data_q == CH_CR) begin
									pend0_d    = CH_LF;
									pend_cnt_d = 2'd1;
									state_d    = ST_ECHO;
								end
							end
						end
					end
					MODE_TX: begin
						if (!echo_sts.empty) begin
							echo_ctl.pop = 1'b1;
							res_line_d   = 1'b1;
							state_d      = ST_READ;
						end else begin
							irq_d = 1'b0;
						end
					end
					MODE_RD: begin
						if (!rx_sts.empty) begin
							rx_ctl.pop = 1'b1;
							res_host_d = 1'b1;
							res_acc_d  = 1'b1;
							state_d    = ST_READ;
						end
					end
					MODE_WR: begin
						if (!echo_sts.full) begin
							echo_ctl.push = 1'b1;
							irq_d         = 1'b1;
							res_acc_d     = 1'b1;
						end
					end
					default: begin
						state_d = ST_FIN;
					end
				endcase
			end
			ST_ECHO: begin
				// One queued echo byte per cycle, each only if there is room.
				echo_ctl.push = !echo_sts.full;
				echo_wdata    = pend0_q;
				pend0_d       = pend1_q;
				pend_cnt_d    = pend_cnt_q - 2'd1;
				if (pend_cnt_q == 2'd1) begin
					state_d = ST_FIN;
				end
			end
			ST_READ: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and history registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_q     <= '0;
			before_q   <= '0;
			lines_q    <= '0;
			irq_q      <= 1'b0;
			pend_cnt_q <= '0;
			res_line_q <= 1'b0;
			res_host_q <= 1'b0;
			res_acc_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			last_q     <= last_d;
			before_q   <= before_d;
			lines_q    <= lines_d;
			irq_q      <= irq_d;
			pend_cnt_q <= pend_cnt_d;
			res_line_q <= res_line_d;
			res_host_q <= res_host_d;
			res_acc_q  <= res_acc_d;
		end
	end

	// Captured event and pending echo bytes.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= item.payload.mode;
			data_q <= item.payload.data_byte;
		end
		pend0_q <= pend0_d;
		pend1_q <= pend1_d;
	end

	// Output register: loaded when the event finishes, cleared by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_q <= out_d;
		end
	end

	`UCLE_ASSERT_NXT(a_pop_then_read, rx_ctl.pop || echo_ctl.pop, state_q == ST_READ,
		"memory read not followed by the read state")
	`UCLE_ASSERT_IMP(a_echo_pending, state_q == ST_ECHO, pend_cnt_q != 2'd0,
		"echo state with nothing pending")
	`UCLE_ASSERT_NXT(a_fin_loads, (state_q == ST_FIN) && out_free, result.valid && state_q == ST_IDLE,
		"finished event did not load the output register")

endmodule
